### src/xwd_pkg.sv
// Shared types and constants for the XOR window stream decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package xwd_pkg;

  localparam int WIN_W          = 7;   // width of the window_k register
  localparam int LEN_W          = 16;  // width of the msg_len register
  localparam int CFG_W          = 16;  // config write data, widest register
  localparam int BYTE_W         = 8;   // tdata width, one byte
  localparam int MAX_WINDOW_DEF = 64;

  typedef enum logic [0:0] {
    CFG_WINDOW_K = 1'b0,
    CFG_MSG_LEN  = 1'b1
  } cfg_idx_t;

  // broadcast from the control logic to every cell
  typedef struct packed {
    logic shift;   // a decoded bit enters the chain
    logic clear;   // start of message: drop the old history
    logic dec;     // the decoded bit of this item
  } cell_ctl_t;

  // one result item
  typedef struct packed {
    logic dec_bit;
    logic last_bit;
  } result_t;

endpackage

### src/xwd_cell.sv
// One cell of the history chain: holds the parity of the newest decoded bits
// up to its own depth. Depends on xwd_pkg.
`timescale 1ns / 1ps

module xwd_cell (
  input  logic              clk,
  input  logic              rst,
  input  xwd_pkg::cell_ctl_t ctl,
  input  logic              prev_par,  // parity held by the neighbor one step nearer
  output logic              par
);
  import xwd_pkg::*;

  logic par_next;

  // after a shift the window of depth i is the new bit plus depth i-1 of before
  always_comb begin
    par_next = par;
    if (ctl.shift) begin
      par_next = ctl.dec ^ (prev_par & ~ctl.clear);
    end else if (ctl.clear) begin
      par_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      par <= 1'b0;
    end else begin
      par <= par_next;
    end
  end

endmodule

### src/xwd_out_skid.sv
// Output register with one skid entry for the result stream.
// Depends on xwd_pkg.
`timescale 1ns / 1ps

module xwd_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xwd_pkg::result_t  push_data,
  output logic              room,       // skid entry free, upstream may send
  output logic              out_valid,
  input  logic              out_ready,
  output xwd_pkg::result_t  out_data
);
  import xwd_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid & out_ready;
  assign room = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a pending output");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid_data))
    else $error("skid entry lost while output stalled");

endmodule

### src/xor_window_stream_decoder.sv
// XOR window stream decoder: one encoded bit in per item, the decoded message
// bit out. Each decoded bit is the encoded bit XOR the parity of the previous
// window_k-1 decoded bits of the message (zero before the message start). A
// start flag on an item begins a new message; only the first msg_len items of
// a message give a result, the last one flagged by tlast. An item is taken
// every cycle while the skid entry is free. The history is a row of
// MAX_WINDOW-1 cells, each holding a running parity that it updates from its
// neighbor in one XOR, so the window parity is a single cell read. The output
// register plus one skid entry keeps input and output sides apart.
// Depends on xwd_pkg, xwd_cell and xwd_out_skid.
`timescale 1ns / 1ps

module xor_window_stream_decoder #(
  parameter int MAX_WINDOW = xwd_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write port
  input  logic                        cfg_we,
  input  xwd_pkg::cfg_idx_t           cfg_addr,
  input  logic [xwd_pkg::CFG_W-1:0]   cfg_wdata,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [xwd_pkg::BYTE_W-1:0]  s_tdata,   // [0] enc_bit, rest zero
  input  logic                        s_tuser,   // [0] start_req
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [xwd_pkg::BYTE_W-1:0]  m_tdata,   // [0] dec_bit, rest zero
  output logic                        m_tlast    // last_bit
);
  import xwd_pkg::*;

  localparam int NCELL = MAX_WINDOW - 1;
  localparam int IDXW  = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int KMAXW = $clog2(MAX_WINDOW + 1);
  localparam int KW    = (KMAXW > WIN_W) ? KMAXW : WIN_W;

  logic [WIN_W-1:0] window_k;
  logic [LEN_W-1:0] msg_len;
  logic [LEN_W-1:0] position;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_k <= WIN_W'(1);
      msg_len  <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WINDOW_K: window_k <= cfg_wdata[WIN_W-1:0];
        CFG_MSG_LEN:  msg_len  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic             accept;
  logic             start;
  logic             enc;
  logic [LEN_W-1:0] pos_eff;
  logic             produce;
  logic             last;
  logic [KW-1:0]    k_eff;
  logic [KW-1:0]    k_raw;
  logic             win_par;
  logic             dec;
  logic [NCELL-1:0] pp;
  cell_ctl_t        ctl;
  result_t          res;
  logic             room;
  result_t          out_res;

  assign enc      = s_tdata[0];
  assign start    = s_tuser;
  assign s_tready = room;
  assign accept   = s_tvalid & s_tready;

  assign pos_eff = start ? '0 : position;
  assign produce = pos_eff < msg_len;
  // pos_eff + 1 cannot wrap while a result is produced
  assign last    = (pos_eff + LEN_W'(1)) == msg_len;

  // window clamped to 1..MAX_WINDOW
  assign k_raw = KW'(window_k);
  always_comb begin
    k_eff = k_raw;
    if (k_raw == '0) begin
      k_eff = KW'(1);
    end else if (k_raw > KW'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end
  end

  // cell k-2 holds the parity of the newest k-1 bits; a start clears it
  always_comb begin
    win_par = 1'b0;
    if (!start && k_eff >= KW'(2)) begin
      win_par = pp[IDXW'(k_eff - KW'(2))];
    end
  end

  assign dec = enc ^ win_par;

  assign ctl.shift = accept & produce;
  assign ctl.clear = accept & start;
  assign ctl.dec   = dec;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic prev;
    if (g == 0) begin : g_first
      assign prev = 1'b0;
    end else begin : g_rest
      assign prev = pp[g-1];
    end
    xwd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .prev_par (prev),
      .par      (pp[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      if (produce) begin
        position <= pos_eff + LEN_W'(1);
      end else if (start) begin
        position <= '0;
      end
    end
  end

  assign res.dec_bit  = dec;
  assign res.last_bit = last;

  xwd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl.shift),
    .push_data (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {{(BYTE_W-1){1'b0}}, out_res.dec_bit};
  assign m_tlast = out_res.last_bit;

  a_start_first: assert property (@(posedge clk) disable iff (rst)
    accept && start && msg_len != '0 |=> position == LEN_W'(1))
    else $error("start item did not become decoded bit one");

  a_cell0_newest: assert property (@(posedge clk) disable iff (rst)
    ctl.shift |=> pp[0] == $past(dec))
    else $error("first cell does not hold the newest decoded bit");

endmodule

### dv/xor_window_stream_decoder_tb.sv
// Self-checking testbench for xor_window_stream_decoder: bursty encoded-bit items in,
// decoded bits checked against a bit-accurate decoder kept in a scoreboard class.
// Depends on xwd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module xor_window_stream_decoder_tb;
  import xwd_pkg::*;

  localparam int HIST_W     = MAX_WINDOW_DEF - 1;
  localparam int CYCLE_CAP  = 500000;
  localparam int HOLD_LEN   = 400;
  localparam int ITEM_GOAL  = 1000;

  // decoded-bit scoreboard: running decoder state plus the queue of expected bits
  class decoded_bit_checker;
    logic [HIST_W-1:0] hist;
    int unsigned       pos;
    logic [WIN_W-1:0]  win;
    logic [LEN_W-1:0]  len;
    result_t           expected_q[$];
    int                errors;
    int                decoded_cnt;

    function new();
      hist        = '0;
      pos         = 0;
      win         = 1;
      len         = 1;
      errors      = 0;
      decoded_cnt = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_WINDOW_K: win = val[WIN_W-1:0];
        CFG_MSG_LEN:  len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_encoded(logic enc, logic start);
      int unsigned       k;
      logic [HIST_W-1:0] mask;
      result_t           r;
      if (start) begin
        hist = '0;
        pos  = 0;
      end
      if (pos >= len) return;
      // window 0 acts as 1, oversize windows saturate
      k = (win == 0) ? 1 : ((win > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win);
      mask = ~({HIST_W{1'b1}} << (k - 1));
      r.dec_bit  = enc ^ (^(hist & mask));
      hist = {hist[HIST_W-2:0], r.dec_bit};
      pos++;
      r.last_bit = (pos == len);
      expected_q.push_back(r);
      decoded_cnt++;
    endfunction

    function void check_decoded(logic dec, logic last);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected decoded item: dec_bit=%0b last_bit=%0b", dec, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e.dec_bit !== dec) begin
        $error("dec_bit mismatch: expected %0b, actual %0b", e.dec_bit, dec);
        errors++;
      end
      if (e.last_bit !== last) begin
        $error("last_bit mismatch: expected %0b, actual %0b", e.last_bit, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  cfg_idx_t          cfg_addr  = CFG_WINDOW_K;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [BYTE_W-1:0] m_tdata;
  logic              m_tlast;

  decoded_bit_checker sb = new();

  bit          tx_gaps    = 1'b0;
  int unsigned burst_left = 0;
  logic        long_hold  = 1'b0;
  int unsigned cycles     = 0;
  int unsigned sent_total = 0;

  xor_window_stream_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // input side first so a same-edge result would still find its expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_encoded(s_tdata[0], s_tuser);
      if (m_tvalid && m_tready) sb.check_decoded(m_tdata[0], m_tlast);
    end
  end

  // receiver: random stall mode picked anew each time rx_cnt wraps; long hold-off on request
  int unsigned rx_cnt   = 0;
  int unsigned rx_mode  = 0;
  int unsigned hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt--;
      if (hold_cnt == 0) long_hold <= 1'b0;
    end else if (long_hold) begin
      m_tready <= 1'b0;
      hold_cnt = HOLD_LEN;
    end else begin
      if (rx_cnt == 0) rx_mode = $urandom_range(0, 3);
      rx_cnt = (rx_cnt == 49) ? 0 : rx_cnt + 1;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  task automatic send_item(input logic enc, input logic start);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(BYTE_W-1){1'b0}}, enc};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    sent_total++;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // wait for every expected item, then wait on for items still in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic configure(input logic [WIN_W-1:0] k, input logic [LEN_W-1:0] n);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_WINDOW_K;
    cfg_wdata <= CFG_W'(k);
    @(posedge clk);
    sb.set_reg(CFG_WINDOW_K, CFG_W'(k));
    cfg_addr  <= CFG_MSG_LEN;
    cfg_wdata <= n;
    @(posedge clk);
    sb.set_reg(CFG_MSG_LEN, n);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned idx);
    logic [WIN_W-1:0] k;
    logic [LEN_W-1:0] n;
    int unsigned      sent;
    int unsigned      first_cnt;
    int unsigned      mlen;
    case ($urandom_range(0, 5))
      0: k = 0;
      1: k = 1;
      2: k = WIN_W'($urandom_range(2, 8));
      3: k = WIN_W'($urandom_range(9, 64));
      4: k = 64;
      default: k = WIN_W'($urandom_range(65, 127));
    endcase
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = 1;
      2: n = 16'hFFFF;
      default: n = LEN_W'($urandom_range(2, 40));
    endcase
    if (idx == 2) n = 16'hFFFF;  // long messages so the hold-off backs up the input
    configure(k, n);
    tx_gaps = (idx % 3 != 0);
    if (idx == 2) long_hold <= 1'b1;
    sent      = 0;
    first_cnt = sb.decoded_cnt;
    while (sb.decoded_cnt - first_cnt < 100 && sent < 150) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        mlen = (n == 0) ? $urandom_range(1, 8) : $urandom_range(1, ((n > 60) ? 60 : n) + 3);
        for (int i = 0; i < mlen; i++) begin
          send_item(1'($urandom_range(0, 1)), i == 0);
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, no start: acts as a message begun at reset
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    drain();
    // window zero and length zero
    configure(7'd0, 16'd0);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b0);
    drain();
    // oversize window saturates, short message plus one ignored item
    configure(7'd127, 16'd3);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    drain();
    // maximum window and length, restart mid message
    configure(7'd64, 16'hFFFF);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    drain();
    // length drops below the position: message finished until the next start
    configure(7'd2, 16'd2);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    drain();

    phase = 0;
    while (sent_total < ITEM_GOAL) begin
      random_phase(phase);
      phase++;
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
